// File: rtl/mce_pkg.sv
`timescale 1ns / 1ps
package mce_pkg;

  localparam int PIX_W       = 4;
  localparam int CELL_PIXELS = 32;
  localparam int ADDR_W      = $clog2(CELL_PIXELS);
  localparam int NUM_COLORS  = 16;
  localparam int COLOR_IDX_W = $clog2(NUM_COLORS);
  localparam int NUM_SLOTS   = 3;

  localparam logic [1:0] KIND_BITMAP = 2'd0;
  localparam logic [1:0] KIND_SCREEN = 2'd1;
  localparam logic [1:0] KIND_COLOR  = 2'd2;

  localparam logic [1:0] CODE_BG    = 2'd0;
  localparam logic [1:0] CODE_FIRST = 2'd1;
  localparam logic [1:0] CODE_SEC   = 2'd2;
  localparam logic [1:0] CODE_OTHER = 2'd3;

  typedef struct packed {
    logic [PIX_W-1:0] s0;
    logic [PIX_W-1:0] s1;
    logic [PIX_W-1:0] s2;
  } slots_t;

  function automatic logic [1:0] pixel_code(input logic [PIX_W-1:0] p,
                                            input logic [PIX_W-1:0] bg,
                                            input slots_t sl);
    logic [1:0] c;
    if (p == bg) c = CODE_BG;
    else if (p == sl.s0) c = CODE_FIRST;
    else if (p == sl.s1) c = CODE_SEC;
    else c = CODE_OTHER;
    return c;
  endfunction

endpackage

// File: rtl/mce_ram.sv
`timescale 1ns / 1ps
module mce_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/mce_pick.sv
`timescale 1ns / 1ps
module mce_pick
  import mce_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [NUM_COLORS-1:0] present,
  output logic                  done,
  output slots_t                slots
);

  logic                   busy;
  logic [COLOR_IDX_W-1:0] c;
  logic [1:0]             found;
  logic                   hit;

  assign hit = present[c] && (found != 2'(NUM_SLOTS));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      c     <= '0;
      found <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        c     <= '0;
        found <= '0;
      end else if (busy) begin
        if (hit) begin
          found <= found + 2'd1;
        end
        c <= c + 1'b1;
        if (c == COLOR_IDX_W'(NUM_COLORS - 1) ||
            (hit && found == 2'(NUM_SLOTS - 1))) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      slots <= '0;
    end else if (busy && hit) begin
      case (found)
        2'd0:    slots.s0 <= c;
        2'd1:    slots.s1 <= c;
        default: slots.s2 <= c;
      endcase
    end
  end

endmodule

// File: rtl/multicolor_cell_encoder.sv
`timescale 1ns / 1ps
// Multicolor cell encoder: takes the 32 wide pixels of one 8x8 cell (4-bit colors, row-major,
// one item per cycle while s_axis_tready is high) and then emits ten bytes: eight bitmap rows,
// the screen byte and the color byte (tlast). After the 32nd pixel the input stalls while the
// block scans the 16 color presence bits one per cycle (ending once three colors are found or
// after the last bit), then rebuilds each row from the pixel RAM with its single read port,
// then sends the last two bytes. A stalled sink holds the row build.
// background_color (cfg_data, written on cfg_we) must be changed only while the block is idle.
module multicolor_cell_encoder
  import mce_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [3:0] cfg_data,       // background_color
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [3:0] pixel_color, [7:4] zero
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [1:0] m_axis_tuser,   // [1:0] byte_kind
  output logic       m_axis_tlast    // last_of_cell
);

  localparam logic [2:0] ST_COLLECT = 3'd0;
  localparam logic [2:0] ST_PICK    = 3'd1;
  localparam logic [2:0] ST_RD      = 3'd2;
  localparam logic [2:0] ST_SH      = 3'd3;
  localparam logic [2:0] ST_ROW     = 3'd4;
  localparam logic [2:0] ST_SCREEN  = 3'd5;
  localparam logic [2:0] ST_COLOR   = 3'd6;

  logic [2:0]            state;
  logic [PIX_W-1:0]      background;
  logic [ADDR_W-1:0]     count;
  logic [ADDR_W-1:0]     idx;
  logic [NUM_COLORS-1:0] color_present;
  logic [7:0]            row;
  logic [PIX_W-1:0]      pix;
  logic [PIX_W-1:0]      rdata;
  logic                  in_acc;
  logic                  out_free;
  logic                  emit;
  logic                  pick_start;
  logic                  pick_done;
  slots_t                slots;
  logic [NUM_COLORS-1:0] present;

  assign pix           = s_axis_tdata[PIX_W-1:0];
  assign s_axis_tready = (state == ST_COLLECT);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign emit          = out_free && (state inside {ST_ROW, ST_SCREEN, ST_COLOR});
  assign pick_start    = in_acc && (count == ADDR_W'(CELL_PIXELS - 1));
  assign present       = color_present & ~(NUM_COLORS'(1) << background);

  mce_ram #(.WIDTH(PIX_W), .DEPTH(CELL_PIXELS)) u_ram (
    .clk   (clk),
    .we    (in_acc),
    .waddr (count),
    .wdata (pix),
    .raddr (idx),
    .rdata (rdata)
  );

  mce_pick u_pick (
    .clk     (clk),
    .rst     (rst),
    .start   (pick_start),
    .present (present),
    .done    (pick_done),
    .slots   (slots)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      background <= '0;
    end else if (cfg_we) begin
      background <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_COLLECT;
      count         <= '0;
      idx           <= '0;
      color_present <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (emit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_COLLECT: begin
          if (in_acc) begin
            count <= count + 1'b1;
            if (pix != background) begin
              color_present <= color_present | (NUM_COLORS'(1) << pix);
            end
            if (pick_start) begin
              state <= ST_PICK;
            end
          end
        end
        ST_PICK: begin
          if (pick_done) begin
            color_present <= '0;
            idx           <= '0;
            state         <= ST_RD;
          end
        end
        ST_RD: begin
          state <= ST_SH;
        end
        ST_SH: begin
          idx <= idx + 1'b1;
          if (idx[1:0] == 2'd3) begin
            state <= ST_ROW;
          end else begin
            state <= ST_RD;
          end
        end
        ST_ROW: begin
          if (out_free) begin
            state <= (idx == '0) ? ST_SCREEN : ST_RD;
          end
        end
        ST_SCREEN: begin
          if (out_free) begin
            state <= ST_COLOR;
          end
        end
        ST_COLOR: begin
          if (out_free) begin
            state <= ST_COLLECT;
          end
        end
        default: begin
          state <= ST_COLLECT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SH) begin
      row <= {row[5:0], pixel_code(rdata, background, slots)};
    end
    if (out_free) begin
      case (state)
        ST_ROW: begin
          m_axis_tdata <= row;
          m_axis_tuser <= KIND_BITMAP;
          m_axis_tlast <= 1'b0;
        end
        ST_SCREEN: begin
          m_axis_tdata <= {slots.s0, slots.s1};
          m_axis_tuser <= KIND_SCREEN;
          m_axis_tlast <= 1'b0;
        end
        ST_COLOR: begin
          m_axis_tdata <= {4'd0, slots.s2};
          m_axis_tuser <= KIND_COLOR;
          m_axis_tlast <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule
